[hdl/prsf_pkg.sv]
// ----------------------------------------------------------------------------
// prsf_pkg: shared types and constants of the rho factor splitter.
// Holds the controller state type, the command and status bundles between
// the controller and the datapath, and the reset values of the registers.
// ----------------------------------------------------------------------------
package prsf_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int IN_W = 64;
	localparam int FACTOR_W = 32;
	localparam int STEP_W = 24;
	localparam int CONST_W = 8;
	localparam int CFG_W = 24;

	localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 24'd1000000;
	localparam logic [CONST_W-1:0] CONST_LIMIT_RESET = 8'd20;
	localparam logic [63:0] FACTOR_MAX = 64'h0000_0000_FFFF_FFFF;

	// Register indexes of the configuration port.
	localparam logic REG_MAX_STEPS = 1'b0;
	localparam logic REG_CONST_LIMIT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_CNEXT, ST_STEPCHK, ST_MX, ST_MY1, ST_MY2,
		ST_DIFF, ST_GCD, ST_CINC, ST_DIV
	} state_t;

	typedef struct packed {
		logic load_n;
		logic emit_fail;
		logic emit_even;
		logic emit_factor;
		logic init_c;
		logic inc_c;
		logic init_walk;
		logic mul_start;
		logic mul_y;
		logic step_inc;
		logic gcd_start;
		logic div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic n_small;
		logic n_even;
		logic c_done;
		logic steps_done;
		logic mul_busy;
		logic diff_zero;
		logic gcd_busy;
		logic d_one;
		logic d_n;
		logic div_busy;
	} dp_status_t;

endpackage

[hdl/prsf_datapath.sv]
// ----------------------------------------------------------------------------
// prsf_datapath: operand registers and serial arithmetic units.
// Holds the number, the walk values, the constant and step counters, a
// bit-serial modular multiplier, a binary gcd unit and a restoring divider.
// ----------------------------------------------------------------------------
module prsf_datapath import prsf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      composite,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           stat,
	output logic                 status,
	output logic [FACTOR_W-1:0]  small_factor,
	output logic [FACTOR_W-1:0]  large_factor
);

	localparam int W = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [STEP_W-1:0]   max_steps_q, steps_q;
	logic [CONST_W-1:0]  const_limit_q, c_q;
	logic [W-1:0]        n_q, x_q, y_q, cm_q;
	logic [W-1:0]        acc_q, ma_q, mb_q;
	logic [CW-1:0]       mcnt_q;
	logic                mul_busy_q, mul_to_y_q;
	logic [W-1:0]        ga_q, gb_q;
	logic                gcd_busy_q;
	logic [W-1:0]        dq_q, dr_q, dn_q;
	logic [CW-1:0]       dcnt_q;
	logic                div_busy_q;
	logic                res_status_q;
	logic [FACTOR_W-1:0] res_small_q, res_large_q;

	logic [W:0]   dbl, dbl_r, sum, sum_r, fin, fin_r, r2;
	logic [W-1:0] acc_next, diff, cm_inc, half, p_lo, p_hi;
	logic         half_wide, fac_wide;

	// One multiplier bit per cycle: double, reduce, conditionally add and reduce.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		sum = dbl_r + {1'b0, mb_q};
		sum_r = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
		acc_next = ma_q[W-1] ? sum_r[W-1:0] : dbl_r[W-1:0];
		fin = {1'b0, acc_q} + {1'b0, cm_q};
		fin_r = (fin >= {1'b0, n_q}) ? fin - {1'b0, n_q} : fin;
		r2 = {dr_q, dn_q[W-1]};
		diff = (x_q > y_q) ? x_q - y_q : y_q - x_q;
		cm_inc = (cm_q + W'(1) == n_q) ? '0 : cm_q + W'(1);
	end

	// Result selection for the even case and the found-factor case.
	always_comb begin
		half = n_q >> 1;
		half_wide = 64'(half) > FACTOR_MAX;
		p_lo = (gb_q > dq_q) ? dq_q : gb_q;
		p_hi = (gb_q > dq_q) ? gb_q : dq_q;
		fac_wide = 64'(p_hi) > FACTOR_MAX;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAX_STEPS_RESET;
			const_limit_q <= CONST_LIMIT_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_MAX_STEPS) begin
				max_steps_q <= cfg_data;
			end else if (cfg_index == REG_CONST_LIMIT) begin
				const_limit_q <= cfg_data[CONST_W-1:0];
			end
		end
	end

	// Walk state, counters and the modular multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			x_q <= '0;
			y_q <= '0;
			cm_q <= '0;
			c_q <= '0;
			steps_q <= '0;
			acc_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			mcnt_q <= '0;
			mul_busy_q <= 1'b0;
			mul_to_y_q <= 1'b0;
		end else begin
			if (cmd.load_n) begin
				n_q <= composite[W-1:0];
			end
			if (cmd.init_c) begin
				c_q <= CONST_W'(1);
				cm_q <= W'(1);
			end else if (cmd.inc_c) begin
				c_q <= c_q + CONST_W'(1);
				cm_q <= cm_inc;
			end
			if (cmd.init_walk) begin
				x_q <= W'(2);
				y_q <= W'(2);
				steps_q <= '0;
			end else if (cmd.step_inc) begin
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.mul_start) begin
				acc_q <= '0;
				ma_q <= cmd.mul_y ? y_q : x_q;
				mb_q <= cmd.mul_y ? y_q : x_q;
				mcnt_q <= '0;
				mul_busy_q <= 1'b1;
				mul_to_y_q <= cmd.mul_y;
			end else if (mul_busy_q) begin
				if (mcnt_q == CW'(W)) begin
					// Square done; add the constant and write back.
					if (mul_to_y_q) begin
						y_q <= fin_r[W-1:0];
					end else begin
						x_q <= fin_r[W-1:0];
					end
					mul_busy_q <= 1'b0;
				end else begin
					acc_q <= acc_next;
					ma_q <= ma_q << 1;
					mcnt_q <= mcnt_q + CW'(1);
				end
			end
		end
	end

	// Binary gcd of the walk difference and the odd number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q <= '0;
			gb_q <= '0;
			gcd_busy_q <= 1'b0;
		end else if (cmd.gcd_start) begin
			ga_q <= diff;
			gb_q <= n_q;
			gcd_busy_q <= 1'b1;
		end else if (gcd_busy_q) begin
			if (ga_q == '0) begin
				gcd_busy_q <= 1'b0;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (ga_q >= gb_q) begin
				ga_q <= ga_q - gb_q;
			end else begin
				ga_q <= gb_q - ga_q;
				gb_q <= ga_q;
			end
		end
	end

	// Restoring divider for the cofactor, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q <= '0;
			dr_q <= '0;
			dn_q <= '0;
			dcnt_q <= '0;
			div_busy_q <= 1'b0;
		end else if (cmd.div_start) begin
			dq_q <= '0;
			dr_q <= '0;
			dn_q <= n_q;
			dcnt_q <= '0;
			div_busy_q <= 1'b1;
		end else if (div_busy_q) begin
			if (r2 >= {1'b0, gb_q}) begin
				dr_q <= W'(r2 - {1'b0, gb_q});
				dq_q <= {dq_q[W-2:0], 1'b1};
			end else begin
				dr_q <= r2[W-1:0];
				dq_q <= {dq_q[W-2:0], 1'b0};
			end
			dn_q <= dn_q << 1;
			dcnt_q <= dcnt_q + CW'(1);
			if (dcnt_q == CW'(W - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= 1'b0;
			res_small_q <= '0;
			res_large_q <= '0;
		end else if (cmd.emit_fail) begin
			res_status_q <= 1'b1;
			res_small_q <= '0;
			res_large_q <= '0;
		end else if (cmd.emit_even) begin
			res_status_q <= half_wide;
			if (half_wide) begin
				res_small_q <= '0;
				res_large_q <= '0;
			end else if (half < W'(2)) begin
				res_small_q <= FACTOR_W'(half);
				res_large_q <= FACTOR_W'(2);
			end else begin
				res_small_q <= FACTOR_W'(2);
				res_large_q <= FACTOR_W'(half);
			end
		end else if (cmd.emit_factor) begin
			res_status_q <= fac_wide;
			res_small_q <= fac_wide ? '0 : FACTOR_W'(p_lo);
			res_large_q <= fac_wide ? '0 : FACTOR_W'(p_hi);
		end
	end

	assign stat.n_small = n_q < W'(2);
	assign stat.n_even = !n_q[0];
	assign stat.c_done = c_q >= const_limit_q;
	assign stat.steps_done = steps_q >= max_steps_q;
	assign stat.mul_busy = mul_busy_q;
	assign stat.diff_zero = x_q == y_q;
	assign stat.gcd_busy = gcd_busy_q;
	assign stat.d_one = gb_q == W'(1);
	assign stat.d_n = gb_q == n_q;
	assign stat.div_busy = div_busy_q;

	assign status = res_status_q;
	assign small_factor = res_small_q;
	assign large_factor = res_large_q;

`ifndef SYNTHESIS
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy_q |-> acc_q < n_q)
		else $error("multiplier accumulator not reduced");
	a_gcd_odd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_busy_q |-> gb_q[0])
		else $error("gcd operand lost oddness");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mul_busy_q, gcd_busy_q, div_busy_q}) <= 1)
		else $error("two arithmetic units busy at once");
`endif

endmodule

[hdl/prsf_controller.sv]
// ----------------------------------------------------------------------------
// prsf_controller: sequencer of the rho walk.
// Steps through the input checks, the constants, the walk steps, the gcd
// and the cofactor division, and issues one result strobe per item.
// ----------------------------------------------------------------------------
module prsf_controller import prsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t stat,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;
	logic   done_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (stat.n_small || stat.n_even) ? ST_IDLE : ST_CNEXT;
			end
			ST_CNEXT: state_d = stat.c_done ? ST_IDLE : ST_STEPCHK;
			ST_STEPCHK: state_d = stat.steps_done ? ST_CINC : ST_MX;
			ST_MX: if (!stat.mul_busy) state_d = ST_MY1;
			ST_MY1: if (!stat.mul_busy) state_d = ST_MY2;
			ST_MY2: if (!stat.mul_busy) state_d = ST_DIFF;
			ST_DIFF: state_d = stat.diff_zero ? ST_CINC : ST_GCD;
			ST_GCD: begin
				if (!stat.gcd_busy) begin
					if (stat.d_one) begin
						state_d = ST_STEPCHK;
					end else if (stat.d_n) begin
						state_d = ST_CINC;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_CINC: state_d = ST_CNEXT;
			ST_DIV: if (!stat.div_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load_n = start;
			ST_CHECK: begin
				cmd.emit_fail = stat.n_small;
				cmd.emit_even = !stat.n_small && stat.n_even;
				cmd.init_c = !stat.n_small && !stat.n_even;
			end
			ST_CNEXT: begin
				cmd.emit_fail = stat.c_done;
				cmd.init_walk = !stat.c_done;
			end
			ST_STEPCHK: cmd.mul_start = !stat.steps_done;
			ST_MX, ST_MY1: begin
				cmd.mul_start = !stat.mul_busy;
				cmd.mul_y = 1'b1;
			end
			ST_MY2: cmd.step_inc = !stat.mul_busy;
			ST_DIFF: cmd.gcd_start = !stat.diff_zero;
			ST_GCD: cmd.div_start = !stat.gcd_busy && !stat.d_one && !stat.d_n;
			ST_CINC: cmd.inc_c = 1'b1;
			ST_DIV: cmd.emit_factor = !stat.div_busy;
			default: cmd = '0;
		endcase
	end

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.emit_fail || cmd.emit_even || cmd.emit_factor;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while still working");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result strobes for one item");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_CHECK)
		else $error("accepted item not taken up");
`endif

endmodule

[hdl/pollard_rho_semiprime_factor.sv]
// ----------------------------------------------------------------------------
// pollard_rho_semiprime_factor: splits a composite into two factors.
// Pollard rho walk with a serial modular multiplier, binary gcd and divider.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one item; busy stays high until
// the result, which appears on status, small_factor and large_factor for
// exactly one cycle with done high and must be taken then. Inputs below two
// and even inputs raise done straight from the input check. For odd inputs
// each walk step runs three modular squarings in the shared bit-serial
// multiplier, then a binary gcd; a found factor adds a division. The walk
// tries the constants 1 to constant_limit-1, each for up to max_steps steps.
// ----------------------------------------------------------------------------
module pollard_rho_semiprime_factor import prsf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [IN_W-1:0]     composite,
	output logic                done,
	output logic                status,
	output logic [FACTOR_W-1:0] small_factor,
	output logic [FACTOR_W-1:0] large_factor,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t stat;

	// Sequencer.
	prsf_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Operand registers and arithmetic units.
	prsf_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.composite    (composite),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.small_factor (small_factor),
		.large_factor (large_factor)
	);

endmodule
